>>> rtl/secs_pkg.sv
`default_nettype none

package secs_pkg;

  localparam int COORD_BITS = 32;
  localparam int EXT_BITS   = COORD_BITS - 1;
  localparam int IDX_BITS   = 10;
  localparam int NVOL_BITS  = 11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                         cmd;
    logic [IDX_BITS-1:0]          entry_index;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [COORD_BITS-1:0] center_z;
    logic [EXT_BITS-1:0]          half_extent;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;
  } in_word_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] container_index;
    logic                found;
  } out_word_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] cz;
    logic [EXT_BITS-1:0]          ext;
  } entry_t;

  typedef struct packed {
    logic wr;     // store the input word's entry
    logic start;  // latch point and count, clear best
    logic issue;  // read entry at scan counter, advance
    logic load;   // move best into output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last_issue;
    logic pipe_empty;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/secs_ctrl.sv
`default_nettype none

module secs_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire logic               cmd_i,
  output logic                    in_stall_o,
  output secs_pkg::ctrl_cmd_t     cmd_o,
  input  wire secs_pkg::ctrl_sts_t sts_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o.wr    = accept && (cmd_i == secs_pkg::CMD_WRITE);
    cmd_o.start = accept && (cmd_i == secs_pkg::CMD_QUERY);
    cmd_o.issue = (state_q == S_SCAN) && !sts_i.count_zero;
    cmd_o.load  = (state_q == S_DRAIN) && sts_i.pipe_empty && sts_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.start) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (sts_i.count_zero || sts_i.last_issue) state_d = S_DRAIN;
      end
      S_DRAIN: begin
        if (cmd_o.load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/secs_dpath.sv
`default_nettype none

module secs_dpath #(
  parameter int MAX_VOLUMES = 1024
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire secs_pkg::in_word_t                in_word_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic                              cfg_ready_i,
  input  wire logic [secs_pkg::NVOL_BITS-1:0]    cfg_data_i,
  input  wire secs_pkg::ctrl_cmd_t               cmd_i,
  output secs_pkg::ctrl_sts_t                    sts_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output secs_pkg::out_word_t                    out_word_o
);

  localparam int AW    = (MAX_VOLUMES > 1) ? $clog2(MAX_VOLUMES) : 1;
  localparam int CNT_W = $clog2(MAX_VOLUMES + 1);
  localparam int CW    = secs_pkg::COORD_BITS;
  localparam int BW    = CW + 1;  // c - h and c + h fit without overflow

  // strict open interval c - h < p < c + h
  function automatic logic in_axis(input logic signed [CW-1:0] p,
                                   input logic signed [CW-1:0] c,
                                   input logic [secs_pkg::EXT_BITS-1:0] h);
    logic signed [BW-1:0] pw, lo, hi, hw;
    pw = BW'(p);
    hw = signed'({2'b00, h});
    lo = BW'(c) - hw;
    hi = BW'(c) + hw;
    return (pw > lo) && (pw < hi);
  endfunction

  logic [secs_pkg::NVOL_BITS-1:0] num_vol_q;
  logic [CNT_W-1:0]               count_q, cnt_q;
  logic signed [CW-1:0]           px_q, py_q, pz_q;

  secs_pkg::entry_t mem_q [MAX_VOLUMES];
  secs_pkg::entry_t rd_q;
  secs_pkg::entry_t wr_entry;
  logic             wr_en;

  logic                          s1_v_q, s2_v_q, s2_in_q;
  logic [AW-1:0]                 s1_idx_q, s2_idx_q, best_idx_q;
  logic [secs_pkg::EXT_BITS-1:0] s2_ext_q, best_ext_q;
  logic                          found_q;
  logic                          take_best;

  logic                 out_valid_q;
  secs_pkg::out_word_t  out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_vol_q <= '0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      num_vol_q <= cfg_data_i;
    end
  end

  // table memory: one write port from the input word, one read port for the scan
  assign wr_en = cmd_i.wr && (int'(in_word_i.entry_index) < MAX_VOLUMES);
  always_comb begin
    wr_entry.cx  = in_word_i.center_x;
    wr_entry.cy  = in_word_i.center_y;
    wr_entry.cz  = in_word_i.center_z;
    wr_entry.ext = in_word_i.half_extent;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[AW'(in_word_i.entry_index)] <= wr_entry;
    end
    if (cmd_i.issue) begin
      rd_q <= mem_q[cnt_q[AW-1:0]];
    end
  end

  // query setup and scan counter
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      px_q <= in_word_i.point_x;
      py_q <= in_word_i.point_y;
      pz_q <= in_word_i.point_z;
      if (int'(num_vol_q) > MAX_VOLUMES) begin
        count_q <= CNT_W'(MAX_VOLUMES);
      end else begin
        count_q <= CNT_W'(num_vol_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      cnt_q <= '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
    if (cmd_i.issue) begin
      s1_idx_q <= cnt_q[AW-1:0];
    end
    if (s1_v_q) begin
      s2_idx_q <= s1_idx_q;
      s2_ext_q <= rd_q.ext;
      s2_in_q  <= in_axis(px_q, rd_q.cx, rd_q.ext) &&
                  in_axis(py_q, rd_q.cy, rd_q.ext) &&
                  in_axis(pz_q, rd_q.cz, rd_q.ext);
    end
    if (cmd_i.start) begin
      best_idx_q <= '0;
    end else if (take_best) begin
      best_idx_q <= s2_idx_q;
      best_ext_q <= s2_ext_q;
    end
  end

  // strict less-than keeps the lowest index on equal extents
  assign take_best = s2_v_q && s2_in_q && (!found_q || (s2_ext_q < best_ext_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.issue;
      s2_v_q <= s1_v_q;
      if (cmd_i.start) begin
        found_q <= 1'b0;
      end else if (take_best) begin
        found_q <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_word_q.container_index <= secs_pkg::IDX_BITS'(best_idx_q);
      out_word_q.found           <= found_q;
    end
  end

  always_comb begin
    sts_o.count_zero = (count_q == '0);
    sts_o.last_issue = ((cnt_q + CNT_W'(1)) == count_q);
    sts_o.pipe_empty = !s1_v_q && !s2_v_q;
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire

>>> rtl/smallest_enclosing_cube_search_core.sv
`default_nettype none

// channel  direction  handshake          word
// in       input      in_valid/in_stall  secs_pkg::in_word_t
// out      output     out_valid/out_stall secs_pkg::out_word_t
// cfg      input      cfg_valid/cfg_ready volume count, 11 bits
//
// A write word is stored in the table when accepted. After a query is accepted, the
// input stalls until its result is loaded into the output register. The scan reads one
// table entry per cycle, up to the clipped volume count, from the single read port of
// the entry memory, followed by a short read/compare/select pipeline.
// Reset clears control state and the volume count; table contents are undefined
// until written. A result waits in the output register while out_stall is high;
// the next word is taken meanwhile, but a finished query holds until it is free.

module smallest_enclosing_cube_search_core #(
  parameter int MAX_VOLUMES = 1024
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire secs_pkg::in_word_t             in_word_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output secs_pkg::out_word_t                 out_word_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [secs_pkg::NVOL_BITS-1:0] cfg_data_i
);

  secs_pkg::ctrl_cmd_t ctrl_cmd;
  secs_pkg::ctrl_sts_t ctrl_sts;

  assign cfg_ready_o = 1'b1;

  secs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .cmd_i      (in_word_i.cmd),
    .in_stall_o (in_stall_o),
    .cmd_o      (ctrl_cmd),
    .sts_i      (ctrl_sts)
  );

  secs_dpath #(
    .MAX_VOLUMES (MAX_VOLUMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (ctrl_cmd),
    .sts_o       (ctrl_sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
